// ===== rtl/wfsc_pkg.sv =====
// Shared types and constants for the wall-follow scan controller.
package wfsc_pkg;

    localparam int RANGE_W = 16;
    localparam int IDX_W   = 9;
    localparam int LIN_W   = 10;
    localparam int ANG_W   = 13;
    localparam int ST_W    = 3;
    localparam int CIDX_W  = 2;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [IDX_W-1:0] RIGHT_COUNT = IDX_W'(30);
    localparam logic [IDX_W-1:0] FRONT_START = IDX_W'(80);
    localparam logic [IDX_W-1:0] FRONT_LAST  = IDX_W'(99);
    localparam logic [IDX_W-1:0] IDX_MAX     = '1;

    localparam logic [RANGE_W-1:0] WALL_RESET      = RANGE_W'(600);
    localparam logic [RANGE_W-1:0] COLLISION_RESET = RANGE_W'(100);
    localparam logic [RANGE_W-1:0] OPEN_RESET      = RANGE_W'(9000);

    localparam logic [RANGE_W-1:0] FOLLOW_FRONT_LO = RANGE_W'(500);
    localparam logic [RANGE_W-1:0] FOLLOW_FRONT_HI = RANGE_W'(900);

    localparam logic [LIN_W-1:0] LIN_FORWARD     = LIN_W'(600);
    localparam logic [LIN_W-1:0] LIN_FOLLOW_TURN = LIN_W'(400);
    localparam logic [LIN_W-1:0] LIN_FOLLOW      = LIN_W'(500);
    localparam logic [LIN_W-1:0] LIN_FIND        = LIN_W'(200);

    localparam logic signed [ANG_W-1:0] ANG_FOLLOW_TURN = ANG_W'(1500);
    localparam logic signed [ANG_W-1:0] ANG_FIND        = -ANG_W'(2300);
    localparam logic signed [ANG_W-1:0] ANG_TURN        = ANG_W'(900);

    typedef enum logic [CIDX_W-1:0] {
        CFG_WALL      = 2'd0,
        CFG_COLLISION = 2'd1,
        CFG_OPEN      = 2'd2
    } cfg_reg_t;

    typedef enum logic [ST_W-1:0] {
        ST_FORWARD = 3'd0,
        ST_FOLLOW  = 3'd1,
        ST_FIND    = 3'd2,
        ST_TURN    = 3'd3,
        ST_BACK    = 3'd4,
        ST_STOP    = 3'd5
    } motion_t;

    typedef struct packed {
        logic [RANGE_W-1:0] right_min;
        logic [RANGE_W-1:0] front_min;
    } scan_sum_t;

    typedef struct packed {
        logic [RANGE_W-1:0] wall;
        logic [RANGE_W-1:0] collision;
        logic [RANGE_W-1:0] open;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

// ===== rtl/wfsc_front.sv =====
// Front end: sample index, window minimums, scan summary at end of scan.
module wfsc_front import wfsc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [RANGE_W-1:0] range_mm,
    input  logic               last_of_scan,
    output logic               push,
    output scan_sum_t          summary
);

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [RANGE_W-1:0] rmin_reg, rmin_next;
    logic [RANGE_W-1:0] fmin_reg, fmin_next;
    logic [RANGE_W-1:0] rmin_upd, fmin_upd;
    logic               in_right, in_front;

    assign in_right = idx_reg < RIGHT_COUNT;
    assign in_front = idx_reg inside {[FRONT_START:FRONT_LAST]};
    assign rmin_upd = (in_right && range_mm < rmin_reg) ? range_mm : rmin_reg;
    assign fmin_upd = (in_front && range_mm < fmin_reg) ? range_mm : fmin_reg;

    assign push              = accept && last_of_scan;
    assign summary.right_min = rmin_upd;
    assign summary.front_min = fmin_upd;

    always_comb begin
        idx_next  = idx_reg;
        rmin_next = rmin_reg;
        fmin_next = fmin_reg;
        if (accept) begin
            if (last_of_scan) begin
                idx_next  = '0;
                rmin_next = '1;
                fmin_next = '1;
            end else begin
                idx_next  = (idx_reg == IDX_MAX) ? idx_reg : idx_reg + IDX_W'(1);
                rmin_next = rmin_upd;
                fmin_next = fmin_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            rmin_reg <= '1;
            fmin_reg <= '1;
        end else begin
            idx_reg  <= idx_next;
            rmin_reg <= rmin_next;
            fmin_reg <= fmin_next;
        end
    end

endmodule

// ===== rtl/wfsc_queue.sv =====
// Two-entry queue of scan summaries between front and back ends.
module wfsc_queue import wfsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  scan_sum_t wr_data,
    input  logic      pop,
    output scan_sum_t rd_data,
    output q_stat_t   status
);

    scan_sum_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign status.valid = cnt_reg != '0;
    assign status.full  = cnt_reg == QCNT_W'(QDEPTH);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/wfsc_back.sv =====
// Back end: speed command, motion state transition, output register.
module wfsc_back import wfsc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_t                      cfg,
    input  q_stat_t                   q_stat,
    input  scan_sum_t                 q_data,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [LIN_W-1:0]          out_lin,
    output logic signed [ANG_W-1:0]   out_ang,
    output motion_t                   out_state,
    output motion_t                   motion
);

    motion_t                  motion_reg, motion_next;
    logic                     valid_reg, valid_next;
    logic [LIN_W-1:0]         lin_reg, lin_cmd;
    logic signed [ANG_W-1:0]  ang_reg, ang_cmd;
    motion_t                  state_reg;
    logic [RANGE_W-1:0]       r, f, d, c, o;
    logic [RANGE_W+3:0]       f_x10, d_x7;
    logic                     tffb, ffb;
    motion_t                  s;

    assign r     = q_data.right_min;
    assign f     = q_data.front_min;
    assign d     = cfg.wall;
    assign c     = cfg.collision;
    assign o     = cfg.open;
    assign f_x10 = (RANGE_W+4)'(f) * (RANGE_W+4)'(10);
    assign d_x7  = (RANGE_W+4)'(d) * (RANGE_W+4)'(7);
    assign q_pop = q_stat.valid && (!valid_reg || out_ready);

    // Command for the state held before this scan.
    always_comb begin
        case (motion_reg)
            ST_FORWARD: begin
                lin_cmd = LIN_FORWARD;
                ang_cmd = '0;
            end
            ST_FOLLOW: begin
                if (f < FOLLOW_FRONT_HI && f > FOLLOW_FRONT_LO) begin
                    lin_cmd = LIN_FOLLOW_TURN;
                    ang_cmd = ANG_FOLLOW_TURN;
                end else begin
                    lin_cmd = LIN_FOLLOW;
                    ang_cmd = '0;
                end
            end
            ST_FIND: begin
                lin_cmd = LIN_FIND;
                ang_cmd = ANG_FIND;
            end
            ST_TURN: begin
                lin_cmd = '0;
                ang_cmd = ANG_TURN;
            end
            default: begin
                lin_cmd = '0;
                ang_cmd = '0;
            end
        endcase
    end

    // Ordered transition rules; each sees the state left by the one before.
    always_comb begin
        s    = motion_reg;
        tffb = 1'b0;
        ffb  = 1'b0;
        if (motion_reg inside {ST_FORWARD, ST_FOLLOW, ST_FIND, ST_TURN, ST_BACK}) begin
            tffb = s inside {ST_TURN, ST_FOLLOW, ST_FIND, ST_BACK};
            if (tffb && r < d && f > d) begin
                s = ST_FOLLOW;
            end
            ffb = s inside {ST_FOLLOW, ST_FIND, ST_BACK};
            if (ffb && r > d && ((f > d && f < o) || f > o)) begin
                s = ST_FIND;
            end
            tffb = s inside {ST_TURN, ST_FOLLOW, ST_FIND, ST_BACK};
            if (tffb && r > d && f > d && r > o && f > o) begin
                s = ST_STOP;
            end
            if (s != ST_STOP && ((r < d && f_x10 < d_x7) || (r > d && f < d))) begin
                s = ST_TURN;
            end
            tffb = s inside {ST_FOLLOW, ST_FIND, ST_TURN, ST_BACK};
            if ((tffb && r < c) || f < c) begin
                s = ST_BACK;
            end
        end
        motion_next = q_pop ? s : motion_reg;
    end

    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            lin_reg   <= lin_cmd;
            ang_reg   <= ang_cmd;
            state_reg <= s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motion_reg <= ST_FORWARD;
            valid_reg  <= 1'b0;
        end else begin
            motion_reg <= motion_next;
            valid_reg  <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lin   = lin_reg;
    assign out_ang   = ang_reg;
    assign out_state = state_reg;
    assign motion    = motion_reg;

endmodule

// ===== rtl/wall_follow_scan_controller_core.sv =====
// A scan's result is queued at its last sample and offered from the result register.
// Throughput: one range sample per cycle; input stalls only while the two-entry
// queue is full behind a result that has not been taken.
// Reset (aresetn low, synchronous): index cleared, minimums at all ones, state forward,
// queue and result register empty, registers at 600, 100 and 9000 mm.
// Top level of the wall-follow scan controller.
module wall_follow_scan_controller_core import wfsc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] range_mm
    input  logic                s_tlast,   // last_of_scan
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [9:0] linear_speed, [22:10] angular_speed,
                                           // [25:23] next_state, [31:26] zero
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [RANGE_W-1:0]  cfg_data
);

    cfg_t                     cfg_reg, cfg_next;
    logic                     accept, push, pop;
    scan_sum_t                wr_sum, rd_sum;
    q_stat_t                  q_stat;
    logic [LIN_W-1:0]         out_lin;
    logic signed [ANG_W-1:0]  out_ang;
    motion_t                  out_state, motion;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WALL:      cfg_next.wall      = cfg_data;
                CFG_COLLISION: cfg_next.collision = cfg_data;
                CFG_OPEN:      cfg_next.open      = cfg_data;
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wall      <= WALL_RESET;
            cfg_reg.collision <= COLLISION_RESET;
            cfg_reg.open      <= OPEN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    wfsc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .range_mm     (s_tdata),
        .last_of_scan (s_tlast),
        .push         (push),
        .summary      (wr_sum)
    );

    wfsc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (wr_sum),
        .pop     (pop),
        .rd_data (rd_sum),
        .status  (q_stat)
    );

    wfsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .q_data    (rd_sum),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_lin   (out_lin),
        .out_ang   (out_ang),
        .out_state (out_state),
        .motion    (motion)
    );

    assign m_tdata = {6'b0, out_state, out_ang, out_lin};

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !accept)
        else $error("scan summary pushed into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pop))
        else $error("result shown without a queue transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        motion == ST_STOP |=> motion == ST_STOP)
        else $error("motion state left stop");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid && out_state == $past(motion_t'(motion) == ST_STOP ? ST_STOP
                                                  : out_state) || $past(motion) != ST_STOP)
        else $error("stop state produced a different next state");

endmodule
